FILE: hdl/mns_pkg.sv
// ----------------------------------------------------------------------------
// mns_pkg
// Types, codes and helpers shared by the MIDI note scheduler modules.
// ----------------------------------------------------------------------------
package mns_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ADDR_W              = 3;
   localparam int DATA_W              = 32;

   localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
   localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
   localparam logic [1:0] REQ_CONTROL  = 2'd2;
   localparam logic [1:0] REQ_TICK     = 2'd3;

   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
   localparam logic [3:0] STATUS_CONTROL  = 4'hB;

   localparam logic REG_DEFAULT_CHANNEL = 1'b0;
   localparam logic REG_HOLD_TIME       = 1'b1;

   localparam logic [4:0]  DEFAULT_CHANNEL_RESET = 5'd1;
   localparam logic [15:0] HOLD_TIME_RESET       = 16'd50;

   typedef struct packed {
      logic [1:0] req_type;
      logic       use_default;
      logic [7:0] channel;
      logic [7:0] number;
      logic [7:0] value;
      logic       host_ready;
   } req_item_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] data_first;
      logic [6:0] data_second;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0]  note;
      logic [3:0]  chan_code;
      logic [31:0] deadline;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctrl_type;

   typedef struct packed {
      logic [4:0]  default_channel;
      logic [15:0] hold_time;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // channel 1..16 after clamping, returned as channel minus one
   function automatic logic [3:0] clamp_code(input logic [7:0] chan);
      logic [3:0] code;
      if (chan == 8'd0) begin
         code = 4'd0;
      end else if (chan > 8'd16) begin
         code = 4'd15;
      end else begin
         code = 4'(chan - 8'd1);
      end
      return code;
   endfunction

endpackage

FILE: hdl/mns_cell.sv
// ----------------------------------------------------------------------------
// mns_cell
// One slot of the pending note list: loads a new entry or takes its right
// neighbour's entry when the list shifts.
// ----------------------------------------------------------------------------
module mns_cell (
   input  logic                  clock,
   input  mns_pkg::cell_ctrl_type ctrl,
   input  logic                  sel,
   input  mns_pkg::entry_type    wr_entry,
   input  mns_pkg::entry_type    right_entry,
   output mns_pkg::entry_type    cell_entry
);

   mns_pkg::entry_type entry_ff;
   mns_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.write && sel) begin
         entry_in = wr_entry;
      end else if (ctrl.shift) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign cell_entry = entry_ff;

endmodule

FILE: hdl/mns_csr.sv
// ----------------------------------------------------------------------------
// mns_csr
// Configuration registers: default channel and note hold time.
// ----------------------------------------------------------------------------
module mns_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mns_pkg::ADDR_W-1:0] paddr,
   input  logic [mns_pkg::DATA_W-1:0] pwdata,
   output logic [mns_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output mns_pkg::cfg_type           cfg
);

   logic [4:0]  default_channel_ff;
   logic [4:0]  default_channel_in;
   logic [15:0] hold_time_ff;
   logic [15:0] hold_time_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      default_channel_in = default_channel_ff;
      hold_time_in       = hold_time_ff;
      if (wr_en) begin
         case (paddr[2])
            mns_pkg::REG_DEFAULT_CHANNEL: begin
               default_channel_in = pwdata[4:0];
            end
            mns_pkg::REG_HOLD_TIME: begin
               hold_time_in = pwdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         mns_pkg::REG_DEFAULT_CHANNEL: prdata = {27'd0, default_channel_ff};
         mns_pkg::REG_HOLD_TIME:       prdata = {16'd0, hold_time_ff};
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_channel_ff <= mns_pkg::DEFAULT_CHANNEL_RESET;
         hold_time_ff       <= mns_pkg::HOLD_TIME_RESET;
      end else begin
         default_channel_ff <= default_channel_in;
         hold_time_ff       <= hold_time_in;
      end
   end

   assign cfg.default_channel = default_channel_ff;
   assign cfg.hold_time       = hold_time_ff;

endmodule

FILE: hdl/midi_note_scheduler.sv
// ----------------------------------------------------------------------------
// midi_note_scheduler
// MIDI note-on / note-off / control-change encoder with automatic note-off.
// A message request gives its result on rsp the cycle after accept.
// A tick is accepted, then walks the list with one step per pending entry
// checking the head cell, then flushes the final result; with no pending
// notes it ends at accept. One request at a time; stalls extend the walk.
// Reset: clears time, pending count and state; config to 1 and 50 ms.
// ----------------------------------------------------------------------------
module midi_note_scheduler #(
   parameter int QUEUE_DEPTH = mns_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mns_pkg::req_item_type      req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mns_pkg::rsp_item_type      rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mns_pkg::ADDR_W-1:0] paddr,
   input  logic [mns_pkg::DATA_W-1:0] pwdata,
   output logic [mns_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   mns_pkg::cfg_type       cfg;
   mns_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          steps_ff, steps_in;
   logic [31:0]            now_ff, now_in;
   logic                   ready_ff, ready_in;
   logic                   held_valid_ff, held_valid_in;
   mns_pkg::rsp_item_type  held_ff, held_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mns_pkg::rsp_item_type  rsp_data_ff, rsp_data_in;

   mns_pkg::cell_ctrl_type ctrl;
   mns_pkg::entry_type     wr_entry;
   mns_pkg::entry_type     new_entry;
   logic [CW-1:0]          wr_pos;
   mns_pkg::entry_type     cells [QUEUE_DEPTH];
   mns_pkg::entry_type     head;

   logic                   out_free;
   logic                   req_accept;
   logic                   expired;
   logic                   emit;
   logic [3:0]             ch_code;
   logic [3:0]             kind;
   mns_pkg::rsp_item_type  msg;

   mns_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      mns_pkg::entry_type right;
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right = wr_entry;
      end else begin : g_body
         assign right = cells[i+1];
      end
      mns_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .sel         (wr_pos == CW'(i)),
         .wr_entry    (wr_entry),
         .right_entry (right),
         .cell_entry  (cells[i])
      );
   end

   assign head       = cells[0];
   assign expired    = now_ff >= head.deadline;
   assign emit       = expired && ready_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !(state_ff == mns_pkg::ST_IDLE && out_free);
   assign req_accept = req_valid && !req_stall;

   assign ch_code = mns_pkg::clamp_code(req_data.use_default ?
                                        {3'd0, cfg.default_channel} : req_data.channel);

   always_comb begin
      case (req_data.req_type)
         mns_pkg::REQ_NOTE_ON:  kind = mns_pkg::STATUS_NOTE_ON;
         mns_pkg::REQ_NOTE_OFF: kind = mns_pkg::STATUS_NOTE_OFF;
         default:               kind = mns_pkg::STATUS_CONTROL;
      endcase
   end

   assign msg.status_byte = {kind, ch_code};
   assign msg.data_first  = req_data.number[6:0];
   assign msg.data_second = (req_data.req_type == mns_pkg::REQ_NOTE_OFF) ?
                            7'd0 : req_data.value[6:0];
   assign msg.last        = 1'b1;

   assign new_entry.note      = req_data.number[6:0];
   assign new_entry.chan_code = ch_code;
   assign new_entry.deadline  = now_ff + {16'd0, cfg.hold_time};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      now_in        = now_ff;
      ready_in      = ready_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ctrl.shift    = 1'b0;
      ctrl.write    = 1'b0;
      wr_entry      = new_entry;
      wr_pos        = count_ff;

      case (state_ff)
         mns_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_data.req_type == mns_pkg::REQ_TICK) begin
                  now_in        = now_ff + 32'd1;
                  ready_in      = req_data.host_ready;
                  steps_in      = count_ff;
                  held_valid_in = 1'b0;
                  state_in      = (count_ff == '0) ? mns_pkg::ST_IDLE : mns_pkg::ST_WALK;
               end else if (req_data.host_ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = msg;
                  if (req_data.req_type == mns_pkg::REQ_NOTE_ON &&
                      count_ff < CW'(QUEUE_DEPTH)) begin
                     ctrl.write = 1'b1;
                     count_in   = count_ff + CW'(1);
                  end
               end
            end
         end
         mns_pkg::ST_WALK: begin
            if (!(emit && held_valid_ff && !out_free)) begin
               // head leaves; a live head goes back in at the end of the list
               ctrl.shift = 1'b1;
               ctrl.write = !expired;
               wr_entry   = head;
               wr_pos     = count_ff - CW'(1);
               if (expired) begin
                  count_in = count_ff - CW'(1);
               end
               if (emit) begin
                  held_in.status_byte = {mns_pkg::STATUS_NOTE_OFF, head.chan_code};
                  held_in.data_first  = head.note;
                  held_in.data_second = 7'd0;
                  held_in.last        = 1'b0;
                  held_valid_in       = 1'b1;
                  if (held_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = held_ff;
                  end
               end
               steps_in = steps_ff - CW'(1);
               if (steps_ff == CW'(1)) begin
                  state_in = mns_pkg::ST_FLUSH;
               end
            end
         end
         mns_pkg::ST_FLUSH: begin
            if (!held_valid_ff) begin
               state_in = mns_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = held_ff;
               rsp_data_in.last = 1'b1;
               held_valid_in    = 1'b0;
               state_in         = mns_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mns_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mns_pkg::ST_IDLE;
         count_ff      <= '0;
         steps_ff      <= '0;
         now_ff        <= '0;
         ready_ff      <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         steps_ff      <= steps_in;
         now_ff        <= now_in;
         ready_ff      <= ready_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("pending count above list depth");

   a_steps_le_count: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= count_ff)
      else $error("walk steps exceed pending entries");

   a_idle_no_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == mns_pkg::ST_IDLE |-> !held_valid_ff)
      else $error("note-off left behind after walk");

   a_tick_time: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.req_type == mns_pkg::REQ_TICK |=>
      now_ff == $past(now_ff) + 32'd1)
      else $error("tick did not advance time");

endmodule

FILE: tb/midi_note_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_scheduler_tb
// Self-checking bench for the MIDI note scheduler. Directed requests cover
// channel clamping, 7-bit masking, every message type, host-not-ready drops,
// a full pending list and the hold-time extremes. Random traffic follows
// under three idling modes, with the registers changed between phases.
// A predictor builds the expected messages for every accepted request, and
// each result is checked against the oldest expectation.
// ----------------------------------------------------------------------------
module midi_note_scheduler_tb;

   localparam int LIST_DEPTH     = mns_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES  = 40;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PHASE_REQUESTS = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   mns_pkg::req_item_type       req_data  = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   mns_pkg::rsp_item_type       rsp_data;
   logic                        psel      = 1'b0;
   logic                        penable   = 1'b0;
   logic                        pwrite    = 1'b0;
   logic [mns_pkg::ADDR_W-1:0]  paddr     = '0;
   logic [mns_pkg::DATA_W-1:0]  pwdata    = '0;
   logic [mns_pkg::DATA_W-1:0]  prdata;
   logic                        pready;

   // predictor state
   logic [4:0]                  cfg_default_channel = mns_pkg::DEFAULT_CHANNEL_RESET;
   logic [15:0]                 cfg_hold_time       = mns_pkg::HOLD_TIME_RESET;
   logic [31:0]                 model_now_ms        = '0;
   mns_pkg::entry_type          held_notes[$];
   mns_pkg::rsp_item_type       expected_msgs[$];

   int                          send_idle_pct = 0;
   int                          recv_idle_pct = 0;
   int                          mismatches    = 0;
   int                          cycle_count   = 0;

   midi_note_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL midi_note_scheduler");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic logic [4:0] clamp_channel(input logic [7:0] chan);
      logic [4:0] ch;
      if (chan < 8'd1) begin
         ch = 5'd1;
      end else if (chan > 8'd16) begin
         ch = 5'd16;
      end else begin
         ch = chan[4:0];
      end
      return ch;
   endfunction

   function automatic mns_pkg::rsp_item_type encode_msg(input logic [3:0] kind,
                                                        input logic [4:0] ch,
                                                        input logic [7:0] d1,
                                                        input logic [7:0] d2);
      mns_pkg::rsp_item_type m;
      m.status_byte = {kind, 4'(ch - 5'd1)};
      m.data_first  = d1[6:0];
      m.data_second = d2[6:0];
      m.last        = 1'b0;
      return m;
   endfunction

   // expected messages for one accepted request; updates time and pending list
   task automatic predict_messages(input mns_pkg::req_item_type r);
      mns_pkg::rsp_item_type burst[$];
      mns_pkg::entry_type    e;
      logic [4:0]            ch;
      int                    i;
      if (r.req_type == mns_pkg::REQ_TICK) begin
         model_now_ms = model_now_ms + 32'd1;
         i = 0;
         while (i < held_notes.size()) begin
            if (model_now_ms >= held_notes[i].deadline) begin
               if (r.host_ready) begin
                  burst.push_back(encode_msg(mns_pkg::STATUS_NOTE_OFF,
                                             5'(held_notes[i].chan_code) + 5'd1,
                                             {1'b0, held_notes[i].note}, 8'd0));
               end
               held_notes.delete(i);
            end else begin
               i++;
            end
         end
      end else if (r.host_ready) begin
         ch = clamp_channel(r.use_default ? {3'b000, cfg_default_channel} : r.channel);
         case (r.req_type)
            mns_pkg::REQ_NOTE_ON: begin
               burst.push_back(encode_msg(mns_pkg::STATUS_NOTE_ON, ch, r.number, r.value));
               if (held_notes.size() < LIST_DEPTH) begin
                  e.note      = r.number[6:0];
                  e.chan_code = 4'(ch - 5'd1);
                  e.deadline  = model_now_ms + {16'd0, cfg_hold_time};
                  held_notes.push_back(e);
               end
            end
            mns_pkg::REQ_NOTE_OFF: begin
               burst.push_back(encode_msg(mns_pkg::STATUS_NOTE_OFF, ch, r.number, 8'd0));
            end
            default: begin
               burst.push_back(encode_msg(mns_pkg::STATUS_CONTROL, ch, r.number, r.value));
            end
         endcase
      end
      if (burst.size() > 0) begin
         burst[burst.size() - 1].last = 1'b1;
      end
      foreach (burst[k]) begin
         expected_msgs.push_back(burst[k]);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
      if (exp !== act) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      mns_pkg::rsp_item_type exp;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_msgs.size() == 0) begin
            $error("unexpected message: status 0x%0h", rsp_data.status_byte);
            mismatches++;
         end else begin
            exp = expected_msgs.pop_front();
            check_field("status_byte", exp.status_byte, rsp_data.status_byte);
            check_field("data_first", {1'b0, exp.data_first}, {1'b0, rsp_data.data_first});
            check_field("data_second", {1'b0, exp.data_second}, {1'b0, rsp_data.data_second});
            check_field("last", {7'd0, exp.last}, {7'd0, rsp_data.last});
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input mns_pkg::req_item_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      predict_messages(r);
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_msgs.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic sel, input logic [15:0] value);
      logic [mns_pkg::DATA_W-1:0] data;
      data = $urandom();
      if (sel == mns_pkg::REG_DEFAULT_CHANNEL) begin
         data[4:0] = value[4:0];
         cfg_default_channel = value[4:0];
      end else begin
         data[15:0] = value;
         cfg_hold_time = value;
      end
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (pready !== 1'b1);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(input logic [4:0] default_channel, input logic [15:0] hold_time);
      wait_for_idle();
      write_register(mns_pkg::REG_DEFAULT_CHANNEL, {11'd0, default_channel});
      write_register(mns_pkg::REG_HOLD_TIME, hold_time);
   endtask

   function automatic mns_pkg::req_item_type make_request(input logic [1:0] kind,
                                                          input logic use_def,
                                                          input logic [7:0] chan,
                                                          input logic [7:0] num,
                                                          input logic [7:0] val,
                                                          input logic ready);
      mns_pkg::req_item_type r;
      r.req_type    = kind;
      r.use_default = use_def;
      r.channel     = chan;
      r.number      = num;
      r.value       = val;
      r.host_ready  = ready;
      return r;
   endfunction

   function automatic mns_pkg::req_item_type random_request();
      mns_pkg::req_item_type r;
      int                    pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         r.req_type = mns_pkg::REQ_NOTE_ON;
      end else if (pick < 45) begin
         r.req_type = mns_pkg::REQ_NOTE_OFF;
      end else if (pick < 58) begin
         r.req_type = mns_pkg::REQ_CONTROL;
      end else begin
         r.req_type = mns_pkg::REQ_TICK;
      end
      r.use_default = ($urandom_range(3) == 0);
      r.channel     = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(17));
      r.number      = 8'($urandom());
      r.value       = 8'($urandom());
      r.host_ready  = ($urandom_range(9) != 0);
      return r;
   endfunction

   task automatic test_message_encoding();
      configure(5'd31, 16'd2);
      send_request(make_request(mns_pkg::REQ_NOTE_ON, 1'b0, 8'd0, 8'hFF, 8'hFF, 1'b1));
      send_request(make_request(mns_pkg::REQ_NOTE_OFF, 1'b0, 8'hFF, 8'h80, 8'h7F, 1'b1));
      send_request(make_request(mns_pkg::REQ_CONTROL, 1'b1, 8'd5, 8'h7F, 8'h80, 1'b1));
      send_request(make_request(mns_pkg::REQ_NOTE_ON, 1'b0, 8'd16, 8'h3C, 8'h40, 1'b0));
      send_request(make_request(mns_pkg::REQ_CONTROL, 1'b0, 8'd17, 8'h07, 8'h00, 1'b0));
   endtask

   // pending note expires while the host is away: dropped silently
   task automatic test_not_ready_tick();
      send_request(make_request(mns_pkg::REQ_TICK, 1'b0, 8'd0, 8'd0, 8'd0, 1'b1));
      send_request(make_request(mns_pkg::REQ_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_request(make_request(mns_pkg::REQ_TICK, 1'b0, 8'd1, 8'd0, 8'd0, 1'b1));
   endtask

   task automatic test_list_full();
      configure(5'd0, 16'd0);
      for (int k = 0; k <= LIST_DEPTH; k++) begin
         send_request(make_request(mns_pkg::REQ_NOTE_ON, k[0], 8'(k * 15), 8'(k * 17),
                                   8'(k * 8), 1'b1));
      end
      send_request(make_request(mns_pkg::REQ_TICK, 1'b0, 8'd0, 8'd0, 8'd0, 1'b1));
   endtask

   task automatic test_long_hold();
      configure(5'd16, 16'hFFFF);
      send_request(make_request(mns_pkg::REQ_NOTE_ON, 1'b1, 8'd3, 8'd60, 8'd100, 1'b1));
      send_request(make_request(mns_pkg::REQ_TICK, 1'b0, 8'd0, 8'd0, 8'd0, 1'b1));
   endtask

   task automatic run_random_phase(input logic [4:0] default_channel, input logic [15:0] hold);
      configure(default_channel, hold);
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
         send_request(random_request());
      end
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic [4:0] ch_a, input logic [15:0] hold_a,
                                      input logic [4:0] ch_b, input logic [15:0] hold_b);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      run_random_phase(ch_a, hold_a);
      run_random_phase(ch_b, hold_b);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_message_encoding();
      test_not_ready_tick();
      test_list_full();
      test_long_hold();
      test_random_traffic(28, 64, 5'd17, 16'd40, 5'd1, 16'd3);
      test_random_traffic(64, 28, 5'd9, 16'd25, 5'd0, 16'd0);
      test_random_traffic(0, 0, 5'd16, 16'd12, 5'd31, 16'd7);
      wait_for_idle();
      if (mismatches == 0 && expected_msgs.size() == 0) begin
         $display("PASS midi_note_scheduler");
      end else begin
         $display("FAIL midi_note_scheduler");
      end
      $finish;
   end

endmodule
